// ===== src/prmq_pkg.sv =====
// Shared types and codes of the priority retry message queue.
package prmq_pkg;

    localparam logic [2:0] MODE_ENQ   = 3'd0;
    localparam logic [2:0] MODE_FETCH = 3'd1;
    localparam logic [2:0] MODE_OUT   = 3'd2;
    localparam logic [2:0] MODE_PRUNE = 3'd3;
    localparam logic [2:0] MODE_CLEAR = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DROPPED = 3'd1;
    localparam logic [2:0] ST_SENT    = 3'd2;
    localparam logic [2:0] ST_RETRY   = 3'd3;
    localparam logic [2:0] ST_EXHAUST = 3'd4;
    localparam logic [2:0] ST_UNKNOWN = 3'd5;
    localparam logic [2:0] ST_EMPTY   = 3'd6;

    localparam logic [1:0] PRIO_LOW    = 2'd0;
    localparam logic [1:0] PRIO_NORMAL = 2'd1;

    localparam logic [2:0] FILL_EMPTY = 3'd0;
    localparam logic [2:0] FILL_25    = 3'd1;
    localparam logic [2:0] FILL_50    = 3'd2;
    localparam logic [2:0] FILL_75    = 3'd3;
    localparam logic [2:0] FILL_FULL  = 3'd4;

    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_RETRY    = 2'd1;
    localparam logic [1:0] CFG_EVICT    = 2'd2;

    localparam logic [21:0] MS_PER_HOUR = 22'd3600000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  priority_req;
        logic [15:0] payload_handle;
        logic [31:0] destination;
        logic [31:0] target_id;
        logic        sent_ok;
        logic [10:0] max_age_hours;
        logic [31:0] now_ms;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] msg_id;
        logic [15:0] out_handle;
        logic [31:0] out_destination;
        logic [7:0]  attempt_count;
        logic [2:0]  status;
        logic [9:0]  removed_count;
        logic [9:0]  queue_count;
        logic [2:0]  fill_state;
        logic        state_changed;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [31:0] id;
        logic [1:0]  prio;
        logic [31:0] stamp;
        logic [7:0]  attempts;
        logic [15:0] handle;
        logic [31:0] dest;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CK,
        S_CMP_RD,
        S_CMP_CK,
        S_FETCH_RD,
        S_FETCH_CK,
        S_ENQ_WR,
        S_RESPOND
    } state_t;

    typedef struct packed {
        logic       latch;
        logic       scan_init;
        logic       scan_ck;
        logic       cmp_init;
        logic       cmp_ck;
        logic       fetch_rd;
        logic       fetch_ck;
        logic       enq_wr;
        logic       clear;
        logic       respond;
        logic       status_we;
        logic [2:0] status_val;
    } cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       count_zero;
        logic       full;
        logic       prio_hi;
        logic       sent_ok;
        logic       sc_hit;
        logic       sc_remove;
        logic       norm_found;
        logic       at_last;
    } sts_t;

endpackage

// ===== src/prmq_ram.sv =====
// Generic single-port-write, registered-read RAM.
module prmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/prmq_ctrl.sv =====
// Sequencing state machine of the message queue.
module prmq_ctrl
    import prmq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output logic busy,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.mode)
                    MODE_ENQ:
                    begin
                        if (!sts.full)
                        begin
                            state_next = S_ENQ_WR;
                        end
                        else if (sts.prio_hi && !sts.count_zero)
                        begin
                            state_next = S_SCAN_RD;
                        end
                        else
                        begin
                            state_next = S_RESPOND;
                        end
                    end
                    MODE_FETCH:
                    begin
                        state_next = sts.count_zero ? S_RESPOND : S_FETCH_RD;
                    end
                    MODE_OUT:
                    begin
                        state_next = sts.count_zero ? S_RESPOND : S_SCAN_RD;
                    end
                    MODE_PRUNE:
                    begin
                        state_next = sts.count_zero ? S_RESPOND : S_CMP_RD;
                    end
                    default:
                    begin
                        state_next = S_RESPOND;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CK;
            end
            S_SCAN_CK:
            begin
                if (sts.sc_hit)
                begin
                    if (sts.mode == MODE_ENQ || sts.sc_remove)
                    begin
                        state_next = S_CMP_RD;
                    end
                    else
                    begin
                        state_next = S_RESPOND;
                    end
                end
                else if (sts.at_last)
                begin
                    if (sts.mode == MODE_ENQ && sts.norm_found)
                    begin
                        state_next = S_CMP_RD;
                    end
                    else
                    begin
                        state_next = S_RESPOND;
                    end
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_CMP_RD:
            begin
                state_next = S_CMP_CK;
            end
            S_CMP_CK:
            begin
                if (sts.at_last)
                begin
                    state_next = (sts.mode == MODE_ENQ) ? S_ENQ_WR : S_RESPOND;
                end
                else
                begin
                    state_next = S_CMP_RD;
                end
            end
            S_FETCH_RD:
            begin
                state_next = S_FETCH_CK;
            end
            S_FETCH_CK:
            begin
                state_next = S_RESPOND;
            end
            S_ENQ_WR:
            begin
                state_next = S_RESPOND;
            end
            S_RESPOND:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.latch = start;
            end
            S_DECODE:
            begin
                unique case (sts.mode)
                    MODE_ENQ:
                    begin
                        if (sts.full)
                        begin
                            if (sts.prio_hi && !sts.count_zero)
                            begin
                                cmd.scan_init = 1'b1;
                            end
                            else
                            begin
                                cmd.status_we  = 1'b1;
                                cmd.status_val = ST_DROPPED;
                            end
                        end
                    end
                    MODE_FETCH:
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.status_we  = 1'b1;
                            cmd.status_val = ST_EMPTY;
                        end
                    end
                    MODE_OUT:
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.status_we  = 1'b1;
                            cmd.status_val = ST_UNKNOWN;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                        end
                    end
                    MODE_PRUNE:
                    begin
                        cmd.cmp_init = !sts.count_zero;
                    end
                    MODE_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                    end
                    default:
                    begin
                        cmd.clear = 1'b0;
                    end
                endcase
            end
            S_SCAN_CK:
            begin
                cmd.scan_ck = 1'b1;
                if (sts.sc_hit)
                begin
                    if (sts.mode == MODE_ENQ)
                    begin
                        cmd.cmp_init = 1'b1;
                    end
                    else
                    begin
                        cmd.cmp_init   = sts.sc_remove;
                        cmd.status_we  = 1'b1;
                        cmd.status_val = sts.sent_ok ? ST_SENT :
                                         (sts.sc_remove ? ST_EXHAUST : ST_RETRY);
                    end
                end
                else if (sts.at_last)
                begin
                    if (sts.mode == MODE_ENQ && sts.norm_found)
                    begin
                        cmd.cmp_init = 1'b1;
                    end
                    else
                    begin
                        cmd.status_we  = 1'b1;
                        cmd.status_val = (sts.mode == MODE_ENQ) ? ST_DROPPED : ST_UNKNOWN;
                    end
                end
            end
            S_CMP_CK:
            begin
                cmd.cmp_ck = 1'b1;
            end
            S_FETCH_RD:
            begin
                cmd.fetch_rd = 1'b1;
            end
            S_FETCH_CK:
            begin
                cmd.fetch_ck = 1'b1;
            end
            S_ENQ_WR:
            begin
                cmd.enq_wr = 1'b1;
            end
            S_RESPOND:
            begin
                cmd.respond = 1'b1;
            end
            default:
            begin
                cmd.respond = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/prmq_dp.sv =====
// Datapath of the message queue: entry memory, counters, registers and result.
module prmq_dp
    import prmq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  req_t        request,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        done,
    output res_t        result
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int FW = ((CW > 10) ? CW : 10) + 2;

    logic [9:0]    cap_reg;
    logic [7:0]    retry_reg;
    logic [31:0]   evict_age_reg;

    req_t          req_reg;
    logic [31:0]   limit_reg;
    logic [CW-1:0] count_reg;
    logic [31:0]   next_id_reg;
    logic [2:0]    notified_reg;
    logic [CW-1:0] cursor_reg;
    logic [CW-1:0] cur0_reg;
    logic [CW-1:0] r_reg;
    logic [CW-1:0] w_reg;
    logic [CW-1:0] idx_reg;
    logic          norm_found_reg;
    logic [CW-1:0] norm_idx_reg;
    logic [CW-1:0] removed_reg;
    logic          done_reg;
    res_t          out_reg;

    logic [31:0]   res_id_reg;
    logic [15:0]   res_handle_reg;
    logic [31:0]   res_dest_reg;
    logic [7:0]    res_att_reg;
    logic [2:0]    res_status_reg;
    logic          res_last_reg;

    entry_t        rdata;
    entry_t        wdata;
    logic          ram_we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;

    logic [FW-1:0] eff_cap;
    logic [FW-1:0] count_x;
    logic [CW-1:0] count_m1;
    logic [CW-1:0] cursor_norm;
    logic [CW-1:0] cursor_inc;
    logic [CW-1:0] cand_idx;
    logic [CW-1:0] count_next;
    logic [31:0]   age;
    logic          aged_norm;
    logic          drop;
    logic [7:0]    att_inc;
    logic [2:0]    fill_now;
    logic          notify;

    prmq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign eff_cap  = (FW'(cap_reg) < FW'(QUEUE_DEPTH)) ? FW'(cap_reg) : FW'(QUEUE_DEPTH);
    assign count_x  = FW'(count_reg);
    assign count_m1 = count_reg - 1'b1;
    assign cursor_norm = (cursor_reg >= count_reg) ? '0 : cursor_reg;
    assign cursor_inc  = cursor_reg + 1'b1;
    assign age       = req_reg.now_ms - rdata.stamp;
    assign aged_norm = (rdata.prio == PRIO_NORMAL) && (age > evict_age_reg);
    assign drop      = (req_reg.mode == MODE_PRUNE) ? (age > limit_reg) : (r_reg == idx_reg);
    assign att_inc   = (rdata.attempts == 8'hFF) ? rdata.attempts : rdata.attempts + 8'd1;
    assign count_next = drop ? w_reg : w_reg + 1'b1;

    // The index to remove: the hit itself, else the first aged normal entry; prune compacts from index 0.
    always_comb
    begin
        if (req_reg.mode == MODE_PRUNE)
        begin
            cand_idx = '0;
        end
        else if (sts.sc_hit || !norm_found_reg)
        begin
            cand_idx = r_reg;
        end
        else
        begin
            cand_idx = norm_idx_reg;
        end
    end

    always_comb
    begin
        sts.mode       = req_reg.mode;
        sts.count_zero = (count_reg == '0);
        sts.full       = (count_x >= eff_cap);
        sts.prio_hi    = req_reg.priority_req[1];
        sts.sent_ok    = req_reg.sent_ok;
        sts.sc_hit     = (req_reg.mode == MODE_ENQ) ? (rdata.prio == PRIO_LOW)
                                                    : (rdata.id == req_reg.target_id);
        sts.sc_remove  = req_reg.sent_ok || (rdata.attempts >= retry_reg);
        sts.norm_found = norm_found_reg || aged_norm;
        sts.at_last    = (r_reg == count_m1);
    end

    always_comb
    begin
        raddr  = cmd.fetch_rd ? cursor_norm[AW-1:0] : r_reg[AW-1:0];
        ram_we = 1'b0;
        waddr  = w_reg[AW-1:0];
        wdata  = rdata;
        if (cmd.cmp_ck)
        begin
            ram_we = !drop;
        end
        else if (cmd.fetch_ck)
        begin
            ram_we         = 1'b1;
            waddr          = cursor_reg[AW-1:0];
            wdata.attempts = att_inc;
        end
        else if (cmd.enq_wr)
        begin
            ram_we         = 1'b1;
            waddr          = count_reg[AW-1:0];
            wdata.id       = next_id_reg;
            wdata.prio     = req_reg.priority_req;
            wdata.stamp    = req_reg.now_ms;
            wdata.attempts = 8'd0;
            wdata.handle   = req_reg.payload_handle;
            wdata.dest     = req_reg.destination;
        end
    end

    always_comb
    begin
        if (count_reg == '0)
        begin
            fill_now = FILL_EMPTY;
        end
        else if (count_x >= eff_cap)
        begin
            fill_now = FILL_FULL;
        end
        else if ((count_x << 2) >= eff_cap * FW'(3))
        begin
            fill_now = FILL_75;
        end
        else if ((count_x << 1) >= eff_cap)
        begin
            fill_now = FILL_50;
        end
        else if ((count_x << 2) >= eff_cap)
        begin
            fill_now = FILL_25;
        end
        else
        begin
            fill_now = FILL_EMPTY;
        end
    end

    assign notify = ((req_reg.mode == MODE_ENQ) && (res_status_reg == ST_OK)) ||
                    (req_reg.mode == MODE_OUT) ||
                    ((req_reg.mode == MODE_PRUNE) && (removed_reg != '0)) ||
                    (req_reg.mode == MODE_CLEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= 10'd500;
            retry_reg     <= 8'd3;
            evict_age_reg <= 32'(MS_PER_HOUR);
            count_reg     <= '0;
            next_id_reg   <= 32'd1;
            notified_reg  <= FILL_EMPTY;
            cursor_reg    <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.respond;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CAPACITY: cap_reg       <= cfg_data[9:0];
                    CFG_RETRY:    retry_reg     <= cfg_data[7:0];
                    CFG_EVICT:    evict_age_reg <= cfg_data;
                    default:      cap_reg       <= cap_reg;
                endcase
            end
            if (cmd.cmp_ck)
            begin
                if (drop && (r_reg < cur0_reg))
                begin
                    cursor_reg <= cursor_reg - 1'b1;
                end
                if (sts.at_last)
                begin
                    count_reg <= count_next;
                end
            end
            if (cmd.fetch_rd)
            begin
                cursor_reg <= cursor_norm;
            end
            if (cmd.fetch_ck)
            begin
                cursor_reg <= (cursor_inc >= count_reg) ? '0 : cursor_inc;
            end
            if (cmd.enq_wr)
            begin
                count_reg   <= count_reg + 1'b1;
                next_id_reg <= (next_id_reg == 32'hFFFF_FFFF) ? 32'd1 : next_id_reg + 32'd1;
            end
            if (cmd.clear)
            begin
                count_reg  <= '0;
                cursor_reg <= '0;
            end
            if (cmd.respond && notify && (fill_now != notified_reg))
            begin
                notified_reg <= fill_now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg        <= request;
            limit_reg      <= 32'(request.max_age_hours) * 32'(MS_PER_HOUR);
            res_id_reg     <= '0;
            res_handle_reg <= '0;
            res_dest_reg   <= '0;
            res_att_reg    <= '0;
            res_status_reg <= ST_OK;
            res_last_reg   <= 1'b0;
            removed_reg    <= '0;
        end
        if (cmd.scan_init)
        begin
            r_reg          <= '0;
            norm_found_reg <= 1'b0;
        end
        if (cmd.scan_ck)
        begin
            if (!cmd.cmp_init)
            begin
                r_reg <= r_reg + 1'b1;
            end
            if ((req_reg.mode == MODE_ENQ) && aged_norm && !norm_found_reg)
            begin
                norm_found_reg <= 1'b1;
                norm_idx_reg   <= r_reg;
            end
            if ((req_reg.mode == MODE_OUT) && sts.sc_hit)
            begin
                res_id_reg     <= rdata.id;
                res_handle_reg <= rdata.handle;
                res_dest_reg   <= rdata.dest;
                res_att_reg    <= rdata.attempts;
            end
        end
        if (cmd.cmp_init)
        begin
            r_reg    <= cand_idx;
            w_reg    <= cand_idx;
            idx_reg  <= cand_idx;
            cur0_reg <= cursor_reg;
        end
        if (cmd.cmp_ck)
        begin
            r_reg <= r_reg + 1'b1;
            if (drop)
            begin
                removed_reg <= removed_reg + 1'b1;
            end
            else
            begin
                w_reg <= w_reg + 1'b1;
            end
        end
        if (cmd.status_we)
        begin
            res_status_reg <= cmd.status_val;
        end
        if (cmd.fetch_ck)
        begin
            res_id_reg     <= rdata.id;
            res_handle_reg <= rdata.handle;
            res_dest_reg   <= rdata.dest;
            res_att_reg    <= att_inc;
            res_last_reg   <= (cursor_inc >= count_reg);
        end
        if (cmd.enq_wr)
        begin
            res_id_reg <= next_id_reg;
        end
        if (cmd.clear)
        begin
            removed_reg <= count_reg;
        end
        if (cmd.respond)
        begin
            out_reg.kind            <= req_reg.mode;
            out_reg.msg_id          <= res_id_reg;
            out_reg.out_handle      <= res_handle_reg;
            out_reg.out_destination <= res_dest_reg;
            out_reg.attempt_count   <= res_att_reg;
            out_reg.status          <= res_status_reg;
            out_reg.removed_count   <= 10'(removed_reg);
            out_reg.queue_count     <= 10'(count_reg);
            out_reg.fill_state      <= fill_now;
            out_reg.state_changed   <= notify && (fill_now != notified_reg);
            out_reg.last            <= res_last_reg;
        end
    end

    assign done   = done_reg;
    assign result = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count exceeds the memory depth");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= count_reg)
        else $error("fetch cursor beyond the held entries");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg != 32'd0)
        else $error("id zero about to be assigned");

    a_enq_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.enq_wr |-> (count_reg < CW'(QUEUE_DEPTH)))
        else $error("enqueue write into a full memory");

endmodule

// ===== src/priority_retry_message_queue.sv =====
// Top level of the priority retry message queue.
// Eviction, send outcome and prune walk the entry memory one entry at a time
// through its single read port, over up to 2 passes of the held count.
// One item at a time; busy stays high until its one-cycle result strobe, never held off.
// Reset empties the queue, sets the next id to 1 and loads register defaults.
module priority_retry_message_queue
    import prmq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        request,
    output logic        done,
    output res_t        result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    prmq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    prmq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

endmodule
